FILE: hw/rtl/lgr_pkg.sv
// ---------------------------------------------------------------------------
// lgr_pkg - shared definitions for the Life row stream unit
// Widths, rule constants, result beat type and the column mask helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgr_pkg;

    // Field widths
    localparam int ROW_BITS_W    = 64;
    localparam int CFG_W         = 7;
    localparam int ROW_CELLS_DEF = 64;

    // Result queue depth: one slot draining plus two written by a last row
    localparam int RES_FIFO_DEPTH = 3;

    // Neighbor counts of the B3/S23 rule
    localparam logic [3:0] LIFE_BIRTH = 4'd3;
    localparam logic [3:0] LIFE_STAY  = 4'd2;

    // Rows of the current frame held in the window (saturates at two)
    localparam logic [1:0] ROWS_NONE = 2'd0;
    localparam logic [1:0] ROWS_ONE  = 2'd1;
    localparam logic [1:0] ROWS_TWO  = 2'd2;

    // One result beat
    typedef struct packed {
        logic [ROW_BITS_W-1:0] bits;
        logic                  done;
    } t_result;

    // Mask of the used columns: width 0 acts as 1, above cells acts as cells
    function automatic logic [ROW_BITS_W-1:0] width_mask(
        input logic [CFG_W-1:0] width,
        input int               cells
    );
        logic [CFG_W-1:0]      used;
        logic [ROW_BITS_W-1:0] m;
        used = width;
        if (used == '0) begin
            used = CFG_W'(1);
        end
        if (int'(used) > cells) begin
            used = CFG_W'(cells);
        end
        for (int k = 0; k < ROW_BITS_W; k++) begin
            m[k] = (k < int'(used));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lgr_intf.sv
// ---------------------------------------------------------------------------
// lgr_intf - valid/ready channels of the Life row stream unit
// Input row channel, result row channel and the width register write channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lgr_row_if;
    logic                             valid;
    logic                             ready;
    logic [lgr_pkg::ROW_BITS_W-1:0]   row_bits;
    logic                             last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

interface lgr_res_if;
    logic                             valid;
    logic                             ready;
    logic [lgr_pkg::ROW_BITS_W-1:0]   next_row_bits;
    logic                             frame_done;

    modport source (output valid, output next_row_bits, output frame_done, input ready);
    modport sink   (input valid, input next_row_bits, input frame_done, output ready);
endinterface

interface lgr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lgr_pkg::CFG_W-1:0]   row_width;

    modport source (output valid, output row_width, input ready);
    modport sink   (input valid, input row_width, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/life_generation_row_stream_unit.sv
// ---------------------------------------------------------------------------
// life_generation_row_stream_unit - streaming Life generation, one row a beat
// Holds a two-row window and emits the updated row above each new row.
// ---------------------------------------------------------------------------
// Rows enter one per clock while i_row.ready is high; an accepted row writes
// its results into a three-entry result queue at its accepting edge, so results
// appear in the cycle after the row that causes them. The output side drains
// one beat per cycle while o_res.ready is high: a frame of N rows (N >= 1)
// yields N result beats in total. When N >= 2 the first row yields none and the
// last row yields two, and that second beat holds i_row.ready low for a cycle at
// each frame end while the result side takes a beat every cycle. i_row.ready is
// high while the queue holds at most one beat. All ROW_CELLS column lanes update
// the whole row in the accepting cycle. The width register can be written at any
// time with no wait; a write applies from the next row on, and rows already held
// are masked with the new width when they are used. No startup pass.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_row_stream_unit #(
    parameter int ROW_CELLS = lgr_pkg::ROW_CELLS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lgr_row_if.sink    i_row,
    lgr_res_if.source  o_res,
    lgr_cfg_if.sink    i_cfg
);

    localparam int RW    = lgr_pkg::ROW_BITS_W;
    localparam int DEPTH = lgr_pkg::RES_FIFO_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [RW-1:0] CELL_MASK =
        lgr_pkg::width_mask(lgr_pkg::CFG_W'(ROW_CELLS), ROW_CELLS);
    localparam logic [RW-1:0] RESET_MASK =
        lgr_pkg::width_mask(lgr_pkg::CFG_W'(64), ROW_CELLS);

    logic [RW-1:0]      r_mask;
    logic [RW-1:0]      r_older, n_older;
    logic [RW-1:0]      r_prev,  n_prev;
    logic [1:0]         r_seen,  n_seen;
    lgr_pkg::t_result   r_q [DEPTH];
    lgr_pkg::t_result   n_q [DEPTH];
    logic [CNT_W-1:0]   r_count, n_count;

    logic               w_in_acc;
    logic               w_pop;
    logic [RW-1:0]      w_cur;
    logic [RW-1:0]      w_gen;
    lgr_pkg::t_result   w_res0;
    lgr_pkg::t_result   w_res1;
    logic [1:0]         w_push;
    logic [CNT_W-1:0]   w_base;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_row.ready = (r_count < CNT_W'(DEPTH - 1));
    assign w_in_acc    = i_row.valid & i_row.ready;
    assign o_res.valid = (r_count != '0);
    assign w_pop       = o_res.valid & o_res.ready;
    assign o_res.next_row_bits = r_q[0].bits;
    assign o_res.frame_done    = r_q[0].done;

    // Column mask register, derived on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= RESET_MASK;
        end else if (i_cfg.valid) begin
            r_mask <= lgr_pkg::width_mask(i_cfg.row_width, ROW_CELLS);
        end
    end

    assign w_cur = i_row.row_bits & CELL_MASK;

    // Lane array on the window
    lgr_row_engine #(
        .ROW_CELLS (ROW_CELLS)
    ) u_engine (
        .i_above (r_older & r_mask),
        .i_mid   (r_prev & r_mask),
        .i_below (w_cur & r_mask),
        .i_mask  (r_mask),
        .o_next  (w_gen)
    );

    // Results of the accepted row and window update
    always_comb begin
        w_res0.bits = r_prev & r_mask;
        w_res0.done = 1'b0;
        w_res1.bits = w_cur & r_mask;
        w_res1.done = 1'b1;
        w_push      = 2'd0;
        n_older     = r_older;
        n_prev      = r_prev;
        n_seen      = r_seen;
        if (w_in_acc) begin
            case (r_seen)
                lgr_pkg::ROWS_NONE: begin
                    w_res0.bits = w_cur & r_mask;
                    w_res0.done = 1'b1;
                    w_push      = i_row.last_row ? 2'd1 : 2'd0;
                end
                lgr_pkg::ROWS_ONE: begin
                    w_push = i_row.last_row ? 2'd2 : 2'd1;
                end
                default: begin
                    w_res0.bits = w_gen;
                    w_push      = i_row.last_row ? 2'd2 : 2'd1;
                end
            endcase
            if (i_row.last_row) begin
                n_older = '0;
                n_prev  = '0;
                n_seen  = lgr_pkg::ROWS_NONE;
            end else begin
                n_older = r_prev;
                n_prev  = w_cur;
                n_seen  = (r_seen == lgr_pkg::ROWS_NONE) ? lgr_pkg::ROWS_ONE
                                                         : lgr_pkg::ROWS_TWO;
            end
        end
    end

    // Result queue: head at entry 0, shift on pop, write behind the survivors
    assign w_base  = r_count - CNT_W'(w_pop);
    assign n_count = w_base + CNT_W'(w_push);

    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            n_q[i] = w_pop ? r_q[i+1] : r_q[i];
        end
        n_q[DEPTH-1] = r_q[DEPTH-1];
        for (int i = 0; i < DEPTH; i++) begin
            if ((w_push != 2'd0) && (w_base == CNT_W'(i))) begin
                n_q[i] = w_res0;
            end
            if ((w_push == 2'd2) && (w_base + CNT_W'(1) == CNT_W'(i))) begin
                n_q[i] = w_res1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_prev  <= '0;
            r_seen  <= lgr_pkg::ROWS_NONE;
            r_count <= '0;
        end else begin
            r_older <= n_older;
            r_prev  <= n_prev;
            r_seen  <= n_seen;
            r_count <= n_count;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lgr_cell.sv
// ---------------------------------------------------------------------------
// lgr_cell - one cell lane of the Life update
// Counts the eight neighbors and applies birth on three, survival on 2 or 3.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgr_cell (
    input  wire logic [2:0] i_above,
    input  wire logic [1:0] i_side,
    input  wire logic [2:0] i_below,
    input  wire logic       i_alive,
    output logic            o_next
);

    logic [3:0] w_count;

    // Neighbor population
    assign w_count = 4'(i_above[0]) + 4'(i_above[1]) + 4'(i_above[2])
                   + 4'(i_side[0])  + 4'(i_side[1])
                   + 4'(i_below[0]) + 4'(i_below[1]) + 4'(i_below[2]);

    // B3/S23
    assign o_next = (w_count == lgr_pkg::LIFE_BIRTH)
                  | (i_alive & (w_count == lgr_pkg::LIFE_STAY));

endmodule

`default_nettype wire

FILE: hw/rtl/lgr_row_engine.sv
// ---------------------------------------------------------------------------
// lgr_row_engine - lane array and merge for one row update
// One cell lane per column; the merge keeps edge columns and masks the row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgr_row_engine #(
    parameter int ROW_CELLS = lgr_pkg::ROW_CELLS_DEF
) (
    input  wire logic [lgr_pkg::ROW_BITS_W-1:0] i_above,
    input  wire logic [lgr_pkg::ROW_BITS_W-1:0] i_mid,
    input  wire logic [lgr_pkg::ROW_BITS_W-1:0] i_below,
    input  wire logic [lgr_pkg::ROW_BITS_W-1:0] i_mask,
    output logic      [lgr_pkg::ROW_BITS_W-1:0] o_next
);

    localparam int RW = lgr_pkg::ROW_BITS_W;

    logic [RW+1:0] w_above_pad;
    logic [RW+1:0] w_mid_pad;
    logic [RW+1:0] w_below_pad;
    logic [RW-1:0] w_lane;
    logic [RW-1:0] w_inner;

    // Dead border around each row so every lane sees three columns
    assign w_above_pad = {1'b0, i_above, 1'b0};
    assign w_mid_pad   = {1'b0, i_mid,   1'b0};
    assign w_below_pad = {1'b0, i_below, 1'b0};

    // Cell lanes
    for (genvar k = 0; k < RW; k++) begin : g_lane
        if (k < ROW_CELLS) begin : g_cell
            lgr_cell u_cell (
                .i_above (w_above_pad[k+2:k]),
                .i_side  ({w_mid_pad[k+2], w_mid_pad[k]}),
                .i_below (w_below_pad[k+2:k]),
                .i_alive (i_mid[k]),
                .o_next  (w_lane[k])
            );
        end else begin : g_none
            assign w_lane[k] = 1'b0;
        end
    end

    // Interior column: not column 0 and the column to its right is used
    assign w_inner = (i_mask >> 1) & ~RW'(1);

    // Merge: interior columns take the lane, edges pass, unused columns clear
    assign o_next = ((w_inner & w_lane) | (~w_inner & i_mid)) & i_mask;

endmodule

`default_nettype wire

FILE: hw/rtl/lgr_checker.sv
// ---------------------------------------------------------------------------
// lgr_checker - port-level checks for the Life row stream unit
// Watches the row and result channels; bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgr_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_in_last,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [lgr_pkg::ROW_BITS_W-1:0]   i_out_bits,
    input wire logic                             i_out_done
);

    // A result beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_bits) && $stable(i_out_done))
        else $error("stalled result beat changed");

    // With nothing queued the unit takes rows
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("row channel stalled with empty result queue");

    // A last row always leaves a result beat behind it
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("last row produced no result beat");

endmodule

bind life_generation_row_stream_unit lgr_checker u_lgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_row.valid),
    .i_in_ready  (i_row.ready),
    .i_in_last   (i_row.last_row),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_bits  (o_res.next_row_bits),
    .i_out_done  (o_res.frame_done)
);

`default_nettype wire

FILE: test/life_generation_row_stream_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// life_generation_row_stream_unit_tb - self-checking bench for the Life unit
// Streams frames of rows through the unit under several row widths, tracks
// the two-row window in a local model, and checks every result beat in order.
// ---------------------------------------------------------------------------

module life_generation_row_stream_unit_tb;

    import lgr_pkg::*;

    localparam int CELLS       = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ROWS  = 108;
    localparam int NUM_PHASES  = 10;

    typedef struct {
        logic [ROW_BITS_W-1:0] bits;
        logic                  last;
    } t_row_beat;

    logic i_clk;
    logic i_rst_n;

    lgr_row_if row_if ();
    lgr_res_if res_if ();
    lgr_cfg_if cfg_if ();

    life_generation_row_stream_unit #(
        .ROW_CELLS (CELLS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Rows waiting to be driven, and result beats the window predicts
    t_row_beat       pending_rows[$];
    t_result         expected_rows[$];

    // Local copy of the width register and of the row window
    logic [CFG_W-1:0]      cfg_width;
    logic [ROW_BITS_W-1:0] win_older;
    logic [ROW_BITS_W-1:0] win_prev;
    logic [1:0]            win_rows;

    int        idle_pct;
    int        send_gap;
    int        stall_left;
    int        quiet_cycles;
    int        fail_count;
    t_row_beat drv_beat;
    t_result   got_row;
    t_result   want_row;

    // B3/S23 update of the inner columns; edge columns keep their value
    function automatic logic [ROW_BITS_W-1:0] life_rule_row(
        input logic [ROW_BITS_W-1:0] above,
        input logic [ROW_BITS_W-1:0] mid,
        input logic [ROW_BITS_W-1:0] below,
        input int                    w
    );
        logic [ROW_BITS_W-1:0] nxt;
        int                    n;
        nxt = mid;
        if (w < 3) begin
            return nxt;
        end
        for (int k = 1; k + 1 < w; k++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
                n += above[k+d];
                n += below[k+d];
            end
            n += mid[k-1];
            n += mid[k+1];
            if (mid[k]) begin
                nxt[k] = (n == LIFE_STAY) || (n == LIFE_BIRTH);
            end else begin
                nxt[k] = (n == LIFE_BIRTH);
            end
        end
        return nxt;
    endfunction

    // Feed one accepted row into the window and queue the beats it causes
    function automatic void advance_life_window(
        input logic [ROW_BITS_W-1:0] row,
        input logic                  last
    );
        int                    w;
        logic [ROW_BITS_W-1:0] m;
        t_result               r;
        w = (cfg_width == '0) ? 1 : int'(cfg_width);
        if (w > CELLS) begin
            w = CELLS;
        end
        for (int k = 0; k < ROW_BITS_W; k++) begin
            m[k] = (k < w);
        end
        if (win_rows == ROWS_NONE) begin
            if (!last) begin
                win_prev = row;
                win_rows = ROWS_ONE;
                return;
            end
        end else begin
            if (win_rows == ROWS_ONE) begin
                r.bits = win_prev & m;
            end else begin
                r.bits = life_rule_row(win_older & m, win_prev & m, row & m, w) & m;
            end
            r.done = 1'b0;
            expected_rows.push_back(r);
            if (!last) begin
                win_older = win_prev;
                win_prev  = row;
                win_rows  = ROWS_TWO;
                return;
            end
        end
        // last row of the frame passes through and closes it
        r.bits = row & m;
        r.done = 1'b1;
        expected_rows.push_back(r);
        win_older = '0;
        win_prev  = '0;
        win_rows  = ROWS_NONE;
    endfunction

    task automatic push_row(input logic [ROW_BITS_W-1:0] bits, input logic last);
        t_row_beat b;
        b.bits = bits;
        b.last = last;
        pending_rows.push_back(b);
    endtask

    // Hold off until every row is sent and every result beat has come back
    task automatic wait_drained();
        while (pending_rows.size() != 0 || row_if.valid || expected_rows.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_row_width(input logic [CFG_W-1:0] w);
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_if.row_width <= w;
        cfg_if.valid     <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        cfg_width = w;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Row driver: takes beats from the pending queue, idles in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_if.valid <= 1'b0;
        end else begin
            if (row_if.valid && row_if.ready) begin
                advance_life_window(row_if.row_bits, row_if.last_row);
            end
            if (!row_if.valid || row_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    row_if.valid <= 1'b0;
                end else if (pending_rows.size() != 0 && idle_pct != 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(0, 14);
                    row_if.valid <= 1'b0;
                end else if (pending_rows.size() != 0) begin
                    drv_beat = pending_rows.pop_front();
                    row_if.valid    <= 1'b1;
                    row_if.row_bits <= drv_beat.bits;
                    row_if.last_row <= drv_beat.last;
                end else begin
                    row_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stalls in bursts, checks each beat against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got_row.bits = res_if.next_row_bits;
                got_row.done = res_if.frame_done;
                if (expected_rows.size() == 0) begin
                    $error("unexpected result beat: next_row_bits %h frame_done %b",
                           got_row.bits, got_row.done);
                    fail_count++;
                end else begin
                    want_row = expected_rows.pop_front();
                    if (got_row.bits !== want_row.bits) begin
                        $error("next_row_bits mismatch: expected %h, actual %h",
                               want_row.bits, got_row.bits);
                        fail_count++;
                    end
                    if (got_row.done !== want_row.done) begin
                        $error("frame_done mismatch: expected %b, actual %b",
                               want_row.done, got_row.done);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(0, 14);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any beat on any channel ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (row_if.valid && row_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int                    phase_width[NUM_PHASES];
        int                    phase_idle[NUM_PHASES];
        int                    sent;
        int                    frame_len;
        int                    frame_idx;
        int                    pick;
        logic [ROW_BITS_W-1:0] row;

        i_rst_n          = 1'b0;
        row_if.valid     = 1'b0;
        row_if.row_bits  = '0;
        row_if.last_row  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.row_width = CFG_W'(CELLS);
        res_if.ready     = 1'b0;
        cfg_width        = CFG_W'(CELLS);
        win_older        = '0;
        win_prev         = '0;
        win_rows         = ROWS_NONE;
        idle_pct         = 0;
        send_gap         = 0;
        stall_left       = 0;
        quiet_cycles     = 0;
        fail_count       = 0;

        phase_width = '{1, 2, 3, 0, 127, 65, 63, 4, 5, 64};
        phase_width[7] = $urandom_range(6, 62);
        phase_idle  = '{30, 0, 10, 50, 20, 5, 40, 15, 25, 0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at full width
        write_row_width(CFG_W'(64));
        idle_pct = 20;
        push_row('1, 1'b1);                             // one-row frame
        push_row(64'hA5A5_A5A5_A5A5_A5A5, 1'b0);        // two-row frame
        push_row(64'h5A5A_5A5A_5A5A_5A5A, 1'b1);
        push_row(64'h0, 1'b0);                          // vertical blinker turns flat
        push_row(64'h8, 1'b0);
        push_row(64'h8, 1'b0);
        push_row(64'h8, 1'b0);
        push_row(64'h0, 1'b1);
        push_row('1, 1'b0);                             // fully alive block
        push_row('1, 1'b0);
        push_row('1, 1'b1);
        push_row(64'h8000_0000_0000_0001, 1'b0);        // activity at both edges
        push_row(64'hC000_0000_0000_0003, 1'b0);
        push_row(64'h8000_0000_0000_0001, 1'b0);
        push_row(64'h0, 1'b1);
        push_row(64'h0, 1'b0);                          // empty frame
        push_row(64'h0, 1'b0);
        push_row(64'h0, 1'b1);
        push_row(64'h0000_0004_0000_0000, 1'b0);        // glider
        push_row(64'h0000_0008_0000_0000, 1'b0);
        push_row(64'h0000_000E_0000_0000, 1'b0);
        push_row(64'h0, 1'b1);

        // Random frames, one row width per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_row_width(CFG_W'(phase_width[p]));
            idle_pct  = phase_idle[p];
            sent      = 0;
            frame_idx = 0;
            while (sent < PHASE_ROWS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    frame_len = 1;
                end else if (pick < 16) begin
                    frame_len = 2;
                end else if (pick < 90) begin
                    frame_len = $urandom_range(3, 8);
                end else begin
                    frame_len = $urandom_range(9, 24);
                end
                for (int r = 0; r < frame_len; r++) begin
                    case ($urandom_range(0, 9))
                        0: row = '0;
                        1: row = '1;
                        2, 3: row = {$urandom, $urandom} & {$urandom, $urandom} &
                                    {$urandom, $urandom};
                        4: row = {$urandom, $urandom} | {$urandom, $urandom};
                        default: row = {$urandom, $urandom};
                    endcase
                    push_row(row, r == frame_len - 1);
                    // sender holds after the first row of the third frame until the unit has drained
                    if (frame_idx == 2 && r == 0) begin
                        wait_drained();
                    end
                end
                sent += frame_len;
                frame_idx++;
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lgr_pkg.sv
hw/rtl/lgr_intf.sv
hw/rtl/lgr_cell.sv
hw/rtl/lgr_row_engine.sv
hw/rtl/life_generation_row_stream_unit.sv
hw/rtl/lgr_checker.sv
test/life_generation_row_stream_unit_tb.sv
